// File: hdl/canonical_kmer_extractor_assert.svh
// Assertion macros for the canonical k-mer extractor.
// Uses the enclosing module's clock and reset ports; no other dependencies.
`ifndef CANONICAL_KMER_EXTRACTOR_ASSERT_SVH
`define CANONICAL_KMER_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define CKE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cke assertion failed");

// next-cycle implication
`define CKE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cke assertion failed");

`endif

// File: hdl/cke_pkg.sv
// Shared types, constants and helpers for the canonical k-mer extractor.
// No dependencies.
package cke_pkg;

   localparam int OUT_W         = 62;
   localparam int SYM_W         = 8;
   localparam int KLEN_W        = 5;
   localparam int MIN_K         = 20;
   localparam int MAX_K_DEFAULT = 31;
   localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd31;

   localparam logic [SYM_W-1:0] CHAR_NL = 8'h0A;
   localparam logic [SYM_W-1:0] CHAR_GT = 8'h3E;
   localparam logic [SYM_W-1:0] CHAR_A  = 8'h41;
   localparam logic [SYM_W-1:0] CHAR_C  = 8'h43;
   localparam logic [SYM_W-1:0] CHAR_G  = 8'h47;
   localparam logic [SYM_W-1:0] CHAR_T  = 8'h54;

   localparam logic [1:0] CODE_A = 2'h0;
   localparam logic [1:0] CODE_C = 2'h1;
   localparam logic [1:0] CODE_G = 2'h2;
   localparam logic [1:0] CODE_T = 2'h3;

   typedef enum logic [1:0] {
      MODE_HEADER = 2'd0,
      MODE_FILL   = 2'd1,
      MODE_STREAM = 2'd2,
      MODE_RECORD = 2'd3
   } mode_type;

   typedef struct packed {
      logic             valid;
      logic [OUT_W-1:0] kmer;
   } result_type;

   function automatic logic is_base(input logic [SYM_W-1:0] sym);
      return (sym == CHAR_A) || (sym == CHAR_C) || (sym == CHAR_G) || (sym == CHAR_T);
   endfunction

   // non-base bytes map to zero
   function automatic logic [1:0] base_code(input logic [SYM_W-1:0] sym);
      logic [1:0] code;
      case (sym)
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_A;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/cke_core.sv
// Parser state machine, rolling forward/complement windows and canonical select.
// Depends on cke_pkg.
module cke_core import cke_pkg::*; #(
   parameter int MAX_K = MAX_K_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [SYM_W-1:0]  symbol,
   input  logic              file_start,
   input  logic              csr_wr_en,
   input  logic [KLEN_W-1:0] csr_wr_data,
   output result_type        result
);

   localparam int WIN_W = 2 * MAX_K;
   localparam logic [KLEN_W-1:0] KMAX = KLEN_W'(MAX_K);
   localparam logic [KLEN_W-1:0] KMIN = KLEN_W'(MIN_K);

   logic [KLEN_W-1:0] klen_ff;
   mode_type          mode_ff, mode_in, mode_cur;
   logic [WIN_W-1:0]  fw_ff, fw_in, fw_cur, fw_shift;
   logic [WIN_W-1:0]  cw_ff, cw_in, cw_cur, cw_shift;
   logic [WIN_W-1:0]  mask;
   logic [KLEN_W-1:0] fill_ff, fill_in, fill_cur, fill_inc;
   logic [KLEN_W-1:0] effk;
   logic [1:0]        code, comp;
   logic              nl, base, emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= KLEN_RESET;
      end else if (csr_wr_en) begin
         klen_ff <= csr_wr_data;
      end
   end

   assign effk = (klen_ff < KMIN) ? KMIN : ((klen_ff > KMAX) ? KMAX : klen_ff);

   always_comb begin
      for (int i = 0; i < WIN_W; i++) begin
         mask[i] = (6'(i) < {effk, 1'b0});
      end
   end

   // a file start clears the windows and fill count before the byte is parsed as header
   assign mode_cur = file_start ? MODE_HEADER : mode_ff;
   assign fw_cur   = file_start ? '0 : fw_ff;
   assign cw_cur   = file_start ? '0 : cw_ff;
   assign fill_cur = file_start ? '0 : fill_ff;

   assign nl       = (symbol == CHAR_NL);
   assign base     = is_base(symbol);
   assign code     = base_code(symbol);
   assign comp     = base ? ~code : 2'b00;
   assign fill_inc = fill_cur + 5'd1;
   assign fw_shift = ((fw_cur << 2) & mask) | WIN_W'(code);
   assign cw_shift = (cw_cur >> 2) | (WIN_W'(comp) << {effk - 5'd1, 1'b0});

   // next state
   always_comb begin
      mode_in = mode_cur;
      fw_in   = fw_cur;
      cw_in   = cw_cur;
      fill_in = fill_cur;
      case (mode_cur)
         MODE_HEADER: begin
            if (nl) begin
               mode_in = MODE_FILL;
               fill_in = '0;
            end
         end
         MODE_FILL: begin
            if (!nl) begin
               fw_in   = fw_shift;
               cw_in   = cw_shift;
               fill_in = fill_inc;
               if ((fill_inc >= effk) || (fill_inc == '0)) begin
                  mode_in = MODE_STREAM;
                  fill_in = '0;
               end
            end
         end
         MODE_STREAM: begin
            if (base) begin
               fw_in = fw_shift;
               cw_in = cw_shift;
            end else if (symbol == CHAR_GT) begin
               mode_in = MODE_RECORD;
            end
         end
         MODE_RECORD: begin
            if (nl) begin
               mode_in = MODE_STREAM;
            end
         end
         default: begin
            mode_in = MODE_HEADER;
         end
      endcase
   end

   // outputs
   always_comb begin
      case (mode_cur)
         MODE_FILL:   emit = !nl && ((fill_inc >= effk) || (fill_inc == '0));
         MODE_STREAM: emit = base;
         default:     emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         fw_ff   <= '0;
         cw_ff   <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         fw_ff   <= fw_in;
         cw_ff   <= cw_in;
         fill_ff <= fill_in;
      end
   end

   assign result.valid = accept && emit;
   assign result.kmer  = OUT_W'((fw_shift > cw_shift) ? cw_shift : fw_shift);

endmodule

// File: hdl/cke_skid.sv
// Two-entry output buffer: result register plus skid slot.
// Depends on cke_pkg and canonical_kmer_extractor_assert.svh.
`include "canonical_kmer_extractor_assert.svh"

module cke_skid import cke_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  result_type       result,
   output logic             push_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_kmer
);

   logic             out_valid_ff, out_valid_in;
   logic [OUT_W-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [OUT_W-1:0] skid_data_ff, skid_data_in;
   logic             take;

   assign take       = out_valid_ff && rsp_tready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = result.kmer;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.kmer;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kmer   = out_data_ff;

   `CKE_ASSERT_SAME(a_skid_needs_out, skid_valid_ff, out_valid_ff)
   `CKE_ASSERT_SAME(a_no_push_when_full, skid_valid_ff, !result.valid)
   `CKE_ASSERT_NEXT(a_stall_fills_skid, result.valid && out_valid_ff && !rsp_tready,
      skid_valid_ff && (skid_data_ff == $past(result.kmer)))

endmodule

// File: hdl/canonical_kmer_extractor.sv
// Canonical k-mer extractor top level.
// Depends on cke_pkg, cke_core and cke_skid.
//
// Input channel req_*: one FASTA byte per word, req_tuser marks the first
// byte of a file. The first line of a file is skipped as header; the next k
// non-newline bytes fill the window and give one k-mer; then each A/C/G/T
// byte gives one k-mer. A '>' skips the rest of its line.
// Output channel rsp_*: the canonical k-mer, min of forward and reverse
// complement, 2 bits per base (A0 C1 G2 T3).
// csr_wr_en/csr_wr_data write k (saturated to 20..MAX_K); reset value 31.
// Write only while the block is idle.
// The k-mer of an accepted byte is registered in the output buffer before rsp.
// Throughput: one byte per cycle while req_tready is high; the window update
// and the 2*MAX_K-bit compare are combinational from window to output buffer.
// A stalled receiver is absorbed by a two-entry output buffer; req_tready
// drops only when both entries are full and returns as soon as one drains.
// Reset (synchronous) clears windows and fill count, enters header skip and
// empties the output buffer.
module canonical_kmer_extractor import cke_pkg::*; #(
   parameter int MAX_K = MAX_K_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] symbol
   input  logic              req_tuser,   // [0] file_start
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // [61:0] canonical_kmer, [63:62] zero
   input  logic              csr_wr_en,
   input  logic [KLEN_W-1:0] csr_wr_data
);

   result_type       result;
   logic             accept;
   logic [OUT_W-1:0] rsp_kmer;

   assign accept = req_tvalid && req_tready;

   cke_core #(
      .MAX_K (MAX_K)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .symbol      (req_tdata),
      .file_start  (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   cke_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kmer   (rsp_kmer)
   );

   assign rsp_tdata = {2'b00, rsp_kmer};

endmodule
